// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is switched off while reset is held
`define LLSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also holds across reset
`define LLSS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/llss_pkg.sv =====
// ---------------------------------------------------------------------------
// llss_pkg
// Shared constants and types of the spin step unit.
// ---------------------------------------------------------------------------
`default_nettype none

package llss_pkg;

    localparam int SPIN_WIDTH_DEF  = 16;
    localparam int FIELD_WIDTH_DEF = 24;

    localparam int INT_FRAC = 14;
    localparam int S_W      = INT_FRAC + 2;
    localparam int GAIN_W   = 32;
    localparam int PAD_W    = 64;
    localparam int LZ_W     = 6;
    localparam int NORM_W   = 30;
    localparam int SQ_W     = 2 * NORM_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 2;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PREC_GAIN = 1'b0,
        REG_DAMP_GAIN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== rtl/llss_fifo.sv =====
// ---------------------------------------------------------------------------
// llss_fifo
// Short register queue between the front and the back of the spin step unit.
// ---------------------------------------------------------------------------
`default_nettype none

module llss_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output llss_pkg::t_q_status   o_status
);
    import llss_pkg::*;

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== rtl/llss_front.sv =====
// ---------------------------------------------------------------------------
// llss_front
// Input side: clamps the spin to unit range, brings it to Q2.14 and queues.
// ---------------------------------------------------------------------------
`default_nettype none

module llss_front #(
    parameter int SPIN_WIDTH  = llss_pkg::SPIN_WIDTH_DEF,
    parameter int FIELD_WIDTH = llss_pkg::FIELD_WIDTH_DEF
) (
    input  wire logic                          i_valid,
    input  wire logic signed [SPIN_WIDTH-1:0]  i_spin_x,
    input  wire logic signed [SPIN_WIDTH-1:0]  i_spin_y,
    input  wire logic signed [SPIN_WIDTH-1:0]  i_spin_z,
    input  wire logic signed [FIELD_WIDTH-1:0] i_field_x,
    input  wire logic signed [FIELD_WIDTH-1:0] i_field_y,
    input  wire logic signed [FIELD_WIDTH-1:0] i_field_z,
    input  llss_pkg::t_q_status                i_q_status,
    output logic                               o_stall,
    output logic                               o_push,
    output logic [3*llss_pkg::S_W+3*FIELD_WIDTH-1:0] o_item
);
    import llss_pkg::*;

    localparam int SF   = SPIN_WIDTH - 2;
    localparam int SH_L = (SF < INT_FRAC) ? INT_FRAC - SF : 0;
    localparam int SH_R = (SF > INT_FRAC) ? SF - INT_FRAC : 0;
    localparam int W_W  = SPIN_WIDTH + SH_L;
    localparam logic [SPIN_WIDTH-1:0] LIM = {2'b01, {SF{1'b0}}};

    function automatic logic signed [S_W-1:0] spin_in(
        input logic signed [SPIN_WIDTH-1:0] s
    );
        logic [SPIN_WIDTH-1:0] m;
        logic [W_W-1:0]        w;
        logic [S_W-2:0]        m15;
        if (s > $signed(LIM) || s < -$signed(LIM)) begin
            m = LIM;
        end else if (s < 0) begin
            m = -s;
        end else begin
            m = s;
        end
        w   = (W_W'(m) << SH_L) >> SH_R;
        m15 = (S_W-1)'(w);
        return (s < 0) ? -$signed({1'b0, m15}) : $signed({1'b0, m15});
    endfunction

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;
    assign o_item  = {spin_in(i_spin_x), spin_in(i_spin_y), spin_in(i_spin_z),
                      i_field_x, i_field_y, i_field_z};

endmodule

`default_nettype wire

// ===== rtl/llss_back.sv =====
// ---------------------------------------------------------------------------
// llss_back
// Execution pipeline: cross products, gain scaling, Euler update, pipelined
// square root and divide for renormalization, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module llss_back #(
    parameter int SPIN_WIDTH  = llss_pkg::SPIN_WIDTH_DEF,
    parameter int FIELD_WIDTH = llss_pkg::FIELD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [3*llss_pkg::S_W+3*FIELD_WIDTH-1:0] i_item,
    input  llss_pkg::t_q_status                i_q_status,
    output logic                               o_pop,
    input  wire logic [llss_pkg::GAIN_W-1:0]   i_prec_gain,
    input  wire logic [llss_pkg::GAIN_W-1:0]   i_damp_gain,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [SPIN_WIDTH-1:0]       o_new_x,
    output logic signed [SPIN_WIDTH-1:0]       o_new_y,
    output logic signed [SPIN_WIDTH-1:0]       o_new_z,
    output logic                               o_degenerate
);
    import llss_pkg::*;

    localparam int SW     = SPIN_WIDTH;
    localparam int FW     = FIELD_WIDTH;
    localparam int SF     = SW - 2;
    localparam int ITEM_W = 3 * S_W + 3 * FW;
    localparam int C1_W   = FW + 16;
    localparam int C2_W   = FW + 31;
    localparam int V_W    = FW + 32;
    localparam int M_W    = V_W - 1;
    localparam int QW     = SW;
    localparam int NUM_W  = NORM_W + SF + 1;
    localparam logic [QW-1:0] OMAX = {1'b0, {(QW-1){1'b1}}};

    logic en;

    // stage 0: queue head
    logic                    r_v0;
    logic signed [S_W-1:0]   r_s0 [3];
    logic signed [FW-1:0]    r_b0 [3];
    // stage 1: s x B
    logic                    r_v1;
    logic signed [S_W-1:0]   r_s1 [3];
    logic signed [C1_W-1:0]  r_c1 [3];
    // stage 2: s x (s x B)
    logic                    r_v2;
    logic signed [S_W-1:0]   r_s2 [3];
    logic signed [C2_W-1:0]  r_c2 [3];
    logic [PAD_W-1:0]        r_c1m2 [3];
    logic [2:0]              r_c1n2;
    // stage 3: gain products
    logic                    r_v3;
    logic signed [S_W-1:0]   r_s3 [3];
    logic [PAD_W-1:0]        r_p1h [3];
    logic [PAD_W-1:0]        r_p1l [3];
    logic [PAD_W-1:0]        r_p2h [3];
    logic [PAD_W-1:0]        r_p2l [3];
    logic [2:0]              r_c1n3;
    logic [2:0]              r_c2n3;
    // stage 4: scaled terms
    logic                    r_v4;
    logic signed [S_W-1:0]   r_s4 [3];
    logic [M_W-1:0]          r_t1 [3];
    logic [M_W-1:0]          r_t2 [3];
    logic [2:0]              r_c1n4;
    logic [2:0]              r_c2n4;
    // stage 5: updated vector
    logic                    r_v5;
    logic signed [V_W-1:0]   r_vec [3];
    // stage 6: magnitudes
    logic                    r_v6;
    logic [M_W-1:0]          r_m6 [3];
    logic [2:0]              r_n6;
    // stage 7: largest magnitude
    logic                    r_v7;
    logic [M_W-1:0]          r_m7 [3];
    logic [M_W-1:0]          r_mx7;
    logic [2:0]              r_n7;
    logic                    r_d7;
    // stages 8 and 9: leading zero count
    logic                    r_v8;
    logic [M_W-1:0]          r_m8 [3];
    logic [PAD_W-1:0]        r_x8;
    logic [LZ_W-1:0]         r_lz8;
    logic [2:0]              r_n8;
    logic                    r_d8;
    logic                    r_v9;
    logic [M_W-1:0]          r_m9 [3];
    logic [LZ_W-1:0]         r_lz9;
    logic [2:0]              r_n9;
    logic                    r_d9;
    // stage 10: normalized magnitudes
    logic                    r_v10;
    logic [NORM_W-1:0]       r_mn10 [3];
    logic [2:0]              r_n10;
    logic                    r_d10;
    // stage 11: squares
    logic                    r_v11;
    logic [NORM_W-1:0]       r_mn11 [3];
    logic [SQ_W-1:0]         r_sq11 [3];
    logic [2:0]              r_n11;
    logic                    r_d11;
    // stage 12: sum of squares
    logic                    r_v12;
    logic [NORM_W-1:0]       r_mn12 [3];
    logic [SUM_W-1:0]        r_sum12;
    logic [2:0]              r_n12;
    logic                    r_d12;
    // divide setup
    logic                    r_vp;
    logic [NUM_W-1:0]        r_num [3];
    logic [ROOT_W-1:0]       r_den;
    logic [2:0]              r_np;
    logic                    r_dp;
    // output register
    logic                    r_out_valid;
    logic [SW-1:0]           r_out [3];
    logic                    r_out_dg;

    logic signed [C1_W-1:0]  n_c1 [3];
    logic signed [C2_W-1:0]  n_c2 [3];
    logic [C1_W-1:0]         n_c1m [3];
    logic [C2_W-1:0]         n_c2m [3];
    logic [PAD_W-1:0]        n_c2p [3];
    logic [2*PAD_W+GAIN_W-1:0] n_w1 [3];
    logic [2*PAD_W+GAIN_W-1:0] n_w2 [3];
    logic signed [V_W-1:0]   n_st1 [3];
    logic signed [V_W-1:0]   n_st2 [3];
    logic [M_W-1:0]          n_mx;
    logic [PAD_W-1:0]        n_x8;
    logic [LZ_W-1:0]         n_lz8;
    logic [PAD_W-1:0]        n_x9;
    logic [LZ_W-1:0]         n_lz9;
    logic [PAD_W-1:0]        n_sh [3];

    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && !i_q_status.empty;

    always_comb begin
        n_c1[0] = C1_W'(r_s0[1] * r_b0[2]) - C1_W'(r_s0[2] * r_b0[1]);
        n_c1[1] = C1_W'(r_s0[2] * r_b0[0]) - C1_W'(r_s0[0] * r_b0[2]);
        n_c1[2] = C1_W'(r_s0[0] * r_b0[1]) - C1_W'(r_s0[1] * r_b0[0]);
        n_c2[0] = C2_W'(r_s1[1] * r_c1[2]) - C2_W'(r_s1[2] * r_c1[1]);
        n_c2[1] = C2_W'(r_s1[2] * r_c1[0]) - C2_W'(r_s1[0] * r_c1[2]);
        n_c2[2] = C2_W'(r_s1[0] * r_c1[1]) - C2_W'(r_s1[1] * r_c1[0]);
        for (int i = 0; i < 3; i++) begin
            n_c1m[i] = r_c1[i][C1_W-1] ? -r_c1[i] : r_c1[i];
            n_c2m[i] = r_c2[i][C2_W-1] ? -r_c2[i] : r_c2[i];
            n_c2p[i] = PAD_W'(n_c2m[i]);
            n_w1[i]  = {{PAD_W{1'b0}}, r_p1h[i], {GAIN_W{1'b0}}}
                     + {{(PAD_W+GAIN_W){1'b0}}, r_p1l[i]};
            n_w2[i]  = {{PAD_W{1'b0}}, r_p2h[i], {GAIN_W{1'b0}}}
                     + {{(PAD_W+GAIN_W){1'b0}}, r_p2l[i]};
            n_st1[i] = r_c1n4[i] ? -$signed({1'b0, r_t1[i]}) : $signed({1'b0, r_t1[i]});
            n_st2[i] = r_c2n4[i] ? -$signed({1'b0, r_t2[i]}) : $signed({1'b0, r_t2[i]});
            n_sh[i]  = PAD_W'(r_m9[i]) << r_lz9;
        end
        n_mx = r_m6[0];
        if (r_m6[1] > n_mx) begin
            n_mx = r_m6[1];
        end
        if (r_m6[2] > n_mx) begin
            n_mx = r_m6[2];
        end
        n_x8  = PAD_W'(r_mx7);
        n_lz8 = '0;
        if (n_x8[PAD_W-1 -: 32] == '0) begin
            n_x8  = n_x8 << 32;
            n_lz8 = n_lz8 + LZ_W'(32);
        end
        if (n_x8[PAD_W-1 -: 16] == '0) begin
            n_x8  = n_x8 << 16;
            n_lz8 = n_lz8 + LZ_W'(16);
        end
        if (n_x8[PAD_W-1 -: 8] == '0) begin
            n_x8  = n_x8 << 8;
            n_lz8 = n_lz8 + LZ_W'(8);
        end
        n_x9  = r_x8;
        n_lz9 = r_lz8;
        if (n_x9[PAD_W-1 -: 4] == '0) begin
            n_x9  = n_x9 << 4;
            n_lz9 = n_lz9 + LZ_W'(4);
        end
        if (n_x9[PAD_W-1 -: 2] == '0) begin
            n_x9  = n_x9 << 2;
            n_lz9 = n_lz9 + LZ_W'(2);
        end
        if (n_x9[PAD_W-1] == 1'b0) begin
            n_lz9 = n_lz9 + LZ_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
            r_v12 <= 1'b0;
        end else if (en) begin
            r_v0  <= o_pop;
            r_v1  <= r_v0;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_v11 <= r_v10;
            r_v12 <= r_v11;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s0[i]   <= i_item[ITEM_W-1-i*S_W -: S_W];
                r_b0[i]   <= i_item[3*FW-1-i*FW -: FW];
                r_s1[i]   <= r_s0[i];
                r_c1[i]   <= n_c1[i];
                r_s2[i]   <= r_s1[i];
                r_c2[i]   <= n_c2[i];
                r_c1m2[i] <= PAD_W'(n_c1m[i]);
                r_c1n2[i] <= r_c1[i][C1_W-1];
                r_s3[i]   <= r_s2[i];
                r_p1h[i]  <= r_c1m2[i][PAD_W-1 -: GAIN_W] * i_prec_gain;
                r_p1l[i]  <= r_c1m2[i][GAIN_W-1:0] * i_prec_gain;
                r_p2h[i]  <= n_c2p[i][PAD_W-1 -: GAIN_W] * i_damp_gain;
                r_p2l[i]  <= n_c2p[i][GAIN_W-1:0] * i_damp_gain;
                r_c1n3[i] <= r_c1n2[i];
                r_c2n3[i] <= r_c2[i][C2_W-1];
                r_s4[i]   <= r_s3[i];
                r_t1[i]   <= M_W'(n_w1[i] >> (GAIN_W - INT_FRAC));
                r_t2[i]   <= M_W'(n_w2[i] >> GAIN_W);
                r_c1n4[i] <= r_c1n3[i];
                r_c2n4[i] <= r_c2n3[i];
                r_vec[i]  <= (V_W'(r_s4[i]) <<< INT_FRAC) - n_st1[i] - n_st2[i];
                r_m6[i]   <= M_W'(r_vec[i][V_W-1] ? -r_vec[i] : r_vec[i]);
                r_n6[i]   <= r_vec[i][V_W-1];
                r_m7[i]   <= r_m6[i];
                r_m8[i]   <= r_m7[i];
                r_m9[i]   <= r_m8[i];
                r_mn10[i] <= n_sh[i][PAD_W-1 -: NORM_W];
                r_mn11[i] <= r_mn10[i];
                r_sq11[i] <= r_mn10[i] * r_mn10[i];
                r_mn12[i] <= r_mn11[i];
            end
            r_mx7   <= n_mx;
            r_n7    <= r_n6;
            r_d7    <= (r_m6[0] == '0) && (r_m6[1] == '0) && (r_m6[2] == '0);
            r_x8    <= n_x8;
            r_lz8   <= n_lz8;
            r_n8    <= r_n7;
            r_d8    <= r_d7;
            r_lz9   <= n_lz9;
            r_n9    <= r_n8;
            r_d9    <= r_d8;
            r_n10   <= r_n9;
            r_d10   <= r_d9;
            r_n11   <= r_n10;
            r_d11   <= r_d10;
            r_sum12 <= SUM_W'(r_sq11[0]) + SUM_W'(r_sq11[1]) + SUM_W'(r_sq11[2]);
            r_n12   <= r_n11;
            r_d12   <= r_d11;
        end
    end

    // square root, one result bit per stage
    logic [SUM_W-1:0]  w_sx [ROOT_W+1];
    logic [REM_W-1:0]  w_sr [ROOT_W+1];
    logic [ROOT_W-1:0] w_sq [ROOT_W+1];
    logic [NORM_W-1:0] w_sm [ROOT_W+1][3];
    logic [2:0]        w_sn [ROOT_W+1];
    logic              w_sd [ROOT_W+1];
    logic              w_sv [ROOT_W+1];

    assign w_sx[0] = r_sum12;
    assign w_sr[0] = '0;
    assign w_sq[0] = '0;
    assign w_sm[0] = r_mn12;
    assign w_sn[0] = r_n12;
    assign w_sd[0] = r_d12;
    assign w_sv[0] = r_v12;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [REM_W+1:0]  rs;
        logic [REM_W+1:0]  t;
        logic              ge;
        logic              r_vld;
        logic [SUM_W-1:0]  r_x;
        logic [REM_W-1:0]  r_r;
        logic [ROOT_W-1:0] r_q;
        logic [NORM_W-1:0] r_m [3];
        logic [2:0]        r_n;
        logic              r_d;

        always_comb begin
            rs = {w_sr[k], w_sx[k][SUM_W-1 -: 2]};
            t  = {{(REM_W-ROOT_W){1'b0}}, w_sq[k], 2'b01};
            ge = (rs >= t);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (en) begin
                r_vld <= w_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x <= w_sx[k] << 2;
                r_r <= ge ? REM_W'(rs - t) : REM_W'(rs);
                r_q <= {w_sq[k][ROOT_W-2:0], ge};
                r_m <= w_sm[k];
                r_n <= w_sn[k];
                r_d <= w_sd[k];
            end
        end

        assign w_sx[k+1] = r_x;
        assign w_sr[k+1] = r_r;
        assign w_sq[k+1] = r_q;
        assign w_sm[k+1] = r_m;
        assign w_sn[k+1] = r_n;
        assign w_sd[k+1] = r_d;
        assign w_sv[k+1] = r_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (en) begin
            r_vp <= w_sv[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= {1'b0, w_sm[ROOT_W][i], {SF{1'b0}}}
                          + NUM_W'(w_sq[ROOT_W] >> 1);
            end
            r_den <= w_sq[ROOT_W];
            r_np  <= w_sn[ROOT_W];
            r_dp  <= w_sd[ROOT_W];
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    logic [ROOT_W-1:0] w_dr [QW+1][3];
    logic [QW-1:0]     w_dl [QW+1][3];
    logic [QW-1:0]     w_dq [QW+1][3];
    logic [ROOT_W-1:0] w_dd [QW+1];
    logic [2:0]        w_dn [QW+1];
    logic              w_dg [QW+1];
    logic              w_dv [QW+1];

    for (genvar i = 0; i < 3; i++) begin : g_div_in
        assign w_dr[0][i] = ROOT_W'(r_num[i] >> QW);
        assign w_dl[0][i] = r_num[i][QW-1:0];
        assign w_dq[0][i] = '0;
    end
    assign w_dd[0] = r_den;
    assign w_dn[0] = r_np;
    assign w_dg[0] = r_dp;
    assign w_dv[0] = r_vp;

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [ROOT_W:0]   rs [3];
        logic [2:0]        ge;
        logic              r_vld;
        logic [ROOT_W-1:0] r_r [3];
        logic [QW-1:0]     r_l [3];
        logic [QW-1:0]     r_q [3];
        logic [ROOT_W-1:0] r_d;
        logic [2:0]        r_n;
        logic              r_g;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rs[i] = {w_dr[k][i], w_dl[k][i][QW-1]};
                ge[i] = (rs[i] >= {1'b0, w_dd[k]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (en) begin
                r_vld <= w_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    r_r[i] <= ge[i] ? ROOT_W'(rs[i] - {1'b0, w_dd[k]}) : ROOT_W'(rs[i]);
                    r_l[i] <= w_dl[k][i] << 1;
                    r_q[i] <= {w_dq[k][i][QW-2:0], ge[i]};
                end
                r_d <= w_dd[k];
                r_n <= w_dn[k];
                r_g <= w_dg[k];
            end
        end

        assign w_dr[k+1] = r_r;
        assign w_dl[k+1] = r_l;
        assign w_dq[k+1] = r_q;
        assign w_dd[k+1] = r_d;
        assign w_dn[k+1] = r_n;
        assign w_dg[k+1] = r_g;
        assign w_dv[k+1] = r_vld;
    end

    logic [QW-1:0] n_sat [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sat[i] = w_dq[QW][i][QW-1] ? OMAX : w_dq[QW][i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_dg[QW]) begin
                    r_out[i] <= '0;
                end else begin
                    r_out[i] <= w_dn[QW][i] ? -n_sat[i] : n_sat[i];
                end
            end
            r_out_dg <= w_dg[QW];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_new_x      = $signed(r_out[0]);
    assign o_new_y      = $signed(r_out[1]);
    assign o_new_z      = $signed(r_out[2]);
    assign o_degenerate = r_out_dg;

endmodule

`default_nettype wire

// ===== rtl/landau_lifshitz_euler_spin_step_unit.sv =====
// ---------------------------------------------------------------------------
// landau_lifshitz_euler_spin_step_unit
// One explicit Euler step of the Landau-Lifshitz equation with renormalization.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall carries one beat of spin (Q2.14 at
// SPIN_WIDTH 16) and effective field. Output channel: o_valid / i_stall
// carries the renormalized spin and the degenerate flag, one beat per input.
// Gains are written through i_cfg_we / i_cfg_idx / i_cfg_wdata while idle;
// the user must keep to this, as the block itself does not enforce it.
// Throughput: one beat per cycle while the receiver does not stall. An
// accepted input beat passes the four-entry input queue, the 13 arithmetic
// stages, the 31 square root stages, the divide setup register, the
// SPIN_WIDTH divide stages and the output register. When the receiver
// stalls, the output register holds its beat and the pipeline freezes; the
// input queue keeps taking beats until it is full, then o_stall rises.
// Reset (synchronous, active low) empties the queue and pipeline and clears
// both gains to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module landau_lifshitz_euler_spin_step_unit #(
    parameter int SPIN_WIDTH  = llss_pkg::SPIN_WIDTH_DEF,
    parameter int FIELD_WIDTH = llss_pkg::FIELD_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [llss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [llss_pkg::GAIN_W-1:0]      i_cfg_wdata,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic signed [SPIN_WIDTH-1:0]     i_spin_x,
    input  wire logic signed [SPIN_WIDTH-1:0]     i_spin_y,
    input  wire logic signed [SPIN_WIDTH-1:0]     i_spin_z,
    input  wire logic signed [FIELD_WIDTH-1:0]    i_field_x,
    input  wire logic signed [FIELD_WIDTH-1:0]    i_field_y,
    input  wire logic signed [FIELD_WIDTH-1:0]    i_field_z,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic signed [SPIN_WIDTH-1:0]          o_new_x,
    output logic signed [SPIN_WIDTH-1:0]          o_new_y,
    output logic signed [SPIN_WIDTH-1:0]          o_new_z,
    output logic                                  o_degenerate
);
    import llss_pkg::*;

    localparam int ITEM_W = 3 * S_W + 3 * FIELD_WIDTH;

    logic [GAIN_W-1:0] r_prec_gain;
    logic [GAIN_W-1:0] r_damp_gain;
    logic [ITEM_W-1:0] w_push_item;
    logic [ITEM_W-1:0] w_head_item;
    logic              w_push;
    logic              w_pop;
    t_q_status         w_q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec_gain <= '0;
            r_damp_gain <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_PREC_GAIN: r_prec_gain <= i_cfg_wdata;
                REG_DAMP_GAIN: r_damp_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    llss_front #(
        .SPIN_WIDTH  (SPIN_WIDTH),
        .FIELD_WIDTH (FIELD_WIDTH)
    ) u_front (
        .i_valid    (i_valid),
        .i_spin_x   (i_spin_x),
        .i_spin_y   (i_spin_y),
        .i_spin_z   (i_spin_z),
        .i_field_x  (i_field_x),
        .i_field_y  (i_field_y),
        .i_field_z  (i_field_z),
        .i_q_status (w_q_status),
        .o_stall    (o_stall),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    llss_fifo #(
        .WIDTH (ITEM_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_item),
        .i_pop    (w_pop),
        .o_data   (w_head_item),
        .o_status (w_q_status)
    );

    llss_back #(
        .SPIN_WIDTH  (SPIN_WIDTH),
        .FIELD_WIDTH (FIELD_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_head_item),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .i_prec_gain  (r_prec_gain),
        .i_damp_gain  (r_damp_gain),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_new_x      (o_new_x),
        .o_new_y      (o_new_y),
        .o_new_z      (o_new_z),
        .o_degenerate (o_degenerate)
    );

endmodule

`default_nettype wire

// ===== rtl/llss_checker.sv =====
// ---------------------------------------------------------------------------
// llss_checker
// Port-level assertions for the spin step unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module llss_checker #(
    parameter int SPIN_WIDTH = llss_pkg::SPIN_WIDTH_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_stall,
    input wire logic signed [SPIN_WIDTH-1:0] i_new_x,
    input wire logic signed [SPIN_WIDTH-1:0] i_new_y,
    input wire logic signed [SPIN_WIDTH-1:0] i_new_z,
    input wire logic                         i_degenerate
);
    localparam logic [SPIN_WIDTH-1:0] MIN_CODE = {1'b1, {(SPIN_WIDTH-1){1'b0}}};

    `LLSS_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    `LLSS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid && $stable(i_new_x) && $stable(i_new_y) && $stable(i_new_z) && $stable(i_degenerate), "stalled beat changed")

    `LLSS_ASSERT(a_degenerate_zero, i_clk, i_rst_n, i_out_valid && i_degenerate |-> i_new_x == '0 && i_new_y == '0 && i_new_z == '0, "degenerate beat not zero")

    `LLSS_ASSERT(a_no_min_code, i_clk, i_rst_n, i_out_valid |-> i_new_x != MIN_CODE && i_new_y != MIN_CODE && i_new_z != MIN_CODE, "output below saturation range")

endmodule

bind landau_lifshitz_euler_spin_step_unit llss_checker #(
    .SPIN_WIDTH (SPIN_WIDTH)
) u_llss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_valid),
    .i_out_stall  (i_stall),
    .i_new_x      (o_new_x),
    .i_new_y      (o_new_y),
    .i_new_z      (o_new_z),
    .i_degenerate (o_degenerate)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// Spin step unit testbench
// Drives spin and field beats through the Landau-Lifshitz Euler step unit
// under random idling on both channels, predicts each renormalized spin with
// an integer model of the step, and compares every output beat in order.
// ---------------------------------------------------------------------------
`default_nettype none

class spin_scoreboard;
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               degen;
    } t_spin_out;

    bit [31:0]  prec_gain;
    bit [31:0]  damp_gain;
    t_spin_out  pending[$];
    int         errors;
    int         checked;

    function longint clamp_spin(logic signed [15:0] raw);
        longint s;
        s = raw;
        if (s > 16384) s = 16384;
        if (s < -16384) s = -16384;
        return s;
    endfunction

    // x * g / 2^sh, magnitude truncated
    function longint gain_mul(longint x, bit [31:0] g, int sh);
        bit [63:0]  m;
        bit [127:0] p;
        m = (x < 0) ? -x : x;
        p = ({64'd0, m} * {96'd0, g}) >> sh;
        return (x < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] val);
        bit [63:0] res, one;
        res = 0;
        one = 64'd1 << 62;
        while (one > val) one = one >> 2;
        while (one != 0) begin
            if (val >= res + one) begin
                val = val - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    function void note_beat(logic signed [15:0] sx, logic signed [15:0] sy,
                            logic signed [15:0] sz, logic signed [23:0] bx,
                            logic signed [23:0] by, logic signed [23:0] bz);
        longint     s[3], b[3], c1[3], c2[3], v[3];
        bit [63:0]  m[3], mx, sumsq, norm, q;
        int         n;
        t_spin_out  r;
        logic signed [15:0] o[3];
        s[0] = clamp_spin(sx); s[1] = clamp_spin(sy); s[2] = clamp_spin(sz);
        b[0] = bx; b[1] = by; b[2] = bz;
        c1[0] = s[1] * b[2] - s[2] * b[1];
        c1[1] = s[2] * b[0] - s[0] * b[2];
        c1[2] = s[0] * b[1] - s[1] * b[0];
        c2[0] = s[1] * c1[2] - s[2] * c1[1];
        c2[1] = s[2] * c1[0] - s[0] * c1[2];
        c2[2] = s[0] * c1[1] - s[1] * c1[0];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = s[i] * 16384 - gain_mul(c1[i], prec_gain, 18)
                 - gain_mul(c2[i], damp_gain, 32);
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        end else begin
            n = 0;
            while (n < 64 && (mx >> n) != 0) n++;
            sumsq = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = (n > 30) ? (m[i] >> (n - 30)) : (m[i] << (30 - n));
                sumsq += m[i] * m[i];
            end
            norm = int_sqrt(sumsq);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << 14) + (norm >> 1)) / norm;
                if (q > 32767) q = 32767;
                o[i] = (v[i] < 0) ? -q[15:0] : q[15:0];
            end
            r = '{o[0], o[1], o[2], 1'b0};
        end
        pending.push_back(r);
    endfunction

    function void check_beat(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic degen);
        t_spin_out e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected beat %0d %0d %0d %0b", $time, x, y, z, degen);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (x !== e.x || y !== e.y || z !== e.z || degen !== e.degen) begin
            $display("%0t: expected %0d %0d %0d %0b, actual %0d %0d %0d %0b",
                     $time, e.x, e.y, e.z, e.degen, x, y, z, degen);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import llss_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_PREC_GAIN;
    logic [GAIN_W-1:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [15:0] i_spin_x = '0, i_spin_y = '0, i_spin_z = '0;
    logic signed [23:0] i_field_x = '0, i_field_y = '0, i_field_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_new_x, o_new_y, o_new_z;
    logic o_degenerate;

    spin_scoreboard spin_sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int beats_sent;

    landau_lifshitz_euler_spin_step_unit u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            spin_sb.check_beat(o_new_x, o_new_y, o_new_z, o_degenerate);
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic write_gain(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_PREC_GAIN) spin_sb.prec_gain = val;
        else spin_sb.damp_gain = val;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (spin_sb.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic send_beat(logic signed [15:0] sx, logic signed [15:0] sy,
                             logic signed [15:0] sz, logic signed [23:0] bx,
                             logic signed [23:0] by, logic signed [23:0] bz);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        {i_spin_x, i_spin_y, i_spin_z} <= {sx, sy, sz};
        {i_field_x, i_field_y, i_field_z} <= {bx, by, bz};
        do @(posedge i_clk); while (o_stall);
        spin_sb.note_beat(sx, sy, sz, bx, by, bz);
        beats_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_spin();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic signed [23:0] rand_field();
        case ($urandom_range(5))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(512)) - 256);
            2: return 24'($signed($urandom_range(131072)) - 65536);
            default: return 24'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    task automatic random_beats(int count);
        for (int k = 0; k < count; k++)
            send_beat(rand_spin(), rand_spin(), rand_spin(),
                      rand_field(), rand_field(), rand_field());
    endtask

    initial begin
        send_idle_pct = 17;
        recv_idle_pct = 80;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset gains: step leaves the spin unchanged
        send_beat(16'sd16384, 16'sd0, 16'sd0, 24'sd1000, 24'sd0, 24'sd0);
        send_beat(16'sd0, 16'sd0, 16'sd0, 24'sd5, 24'sd6, 24'sd7);
        drain();
        write_gain(REG_PREC_GAIN, 32'h0100_0000);
        write_gain(REG_DAMP_GAIN, 32'h0080_0000);
        send_beat(16'sd0, 16'sd0, 16'sd0, 24'sd8388607, -24'sd8388608, 24'sd1);
        send_beat(16'sd32767, -16'sd32768, 16'sd20000, 24'sd100, 24'sd200, 24'sd300);
        send_beat(16'sd16384, 16'sd0, 16'sd0, 24'sd8388607, 24'sd8388607, 24'sd8388607);
        send_beat(-16'sd16384, -16'sd16384, -16'sd16384,
                  -24'sd8388608, -24'sd8388608, -24'sd8388608);
        send_beat(16'sd0, 16'sd16384, 16'sd0, 24'sd0, 24'sd0, 24'sd4096);
        send_beat(16'sd11585, 16'sd11585, 16'sd0, -24'sd1, 24'sd1, 24'sd0);
        send_beat(16'sd1, -16'sd1, 16'sd1, 24'sd0, 24'sd0, 24'sd0);
        send_beat(16'sd16384, 16'sd16384, 16'sd16384, 24'sd0, 24'sd0, 24'sd0);
        send_beat(16'sd0, 16'sd0, 16'sd16384, 24'sd65536, 24'sd0, 24'sd0);
        drain();
        write_gain(REG_PREC_GAIN, 32'hFFFF_FFFF);
        write_gain(REG_DAMP_GAIN, 32'hFFFF_FFFF);
        send_beat(16'sd16384, 16'sd0, 16'sd0, 24'sd0, 24'sd8388607, 24'sd0);
        send_beat(16'sd0, 16'sd16384, 16'sd0, 24'sd0, 24'sd0, -24'sd8388608);
        send_beat(16'sd9459, 16'sd9459, 16'sd9459, 24'sd3, -24'sd2, 24'sd1);
        send_beat(-16'sd1, 16'sd0, 16'sd0, 24'sd1, 24'sd1, 24'sd1);
        random_beats(60);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 17 : 0;
            for (int g = 0; g < 3; g++) begin
                write_gain(REG_PREC_GAIN, (g == 0) ? 32'd0 : $urandom);
                write_gain(REG_DAMP_GAIN,
                           (g == 1) ? 32'd0 : ($urandom >> $urandom_range(16)));
                random_beats(30);
                // hold off until the pipeline has emptied
                i_valid <= 1'b0;
                while (spin_sb.pending.size() != 0) @(negedge i_clk);
                random_beats(35);
                drain();
            end
        end

        $display("covered %0d beats, %0d results checked, gains from zero to full scale",
                 beats_sent, spin_sb.checked);
        $display("three idling phases on both channels, degenerate and clamped spins");
        if (spin_sb.errors == 0 && spin_sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule

`default_nettype wire
